// ===== hw/rtl/pst_pkg.sv =====
package pst_pkg;

  localparam int NUM_SWITCHES = 8;

  localparam int IDX_W   = 3;
  localparam int SEL_W   = 3;
  localparam int PORT_W  = 8;
  localparam int TIME_W  = 32;
  localparam int EN_W    = 8;
  localparam int MAP_W   = 24;
  localparam int MIN_W   = 16;
  localparam int CFG_A_W = 2;

  localparam logic [CFG_A_W-1:0] REG_SWITCH_ENABLE  = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_SWITCH_BIT_MAP = 2'd1;
  localparam logic [CFG_A_W-1:0] REG_MIN_PRESS_US   = 2'd2;

  localparam logic [EN_W-1:0]  SWITCH_ENABLE_RST  = 8'h00;
  localparam logic [MAP_W-1:0] SWITCH_BIT_MAP_RST = 24'hFAC688;
  localparam logic [MIN_W-1:0] MIN_PRESS_US_RST   = 16'd1000;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SWITCHES - 1);

  typedef struct packed {
    logic             load;
    logic             emit;
    logic [IDX_W-1:0] idx;
  } pst_cmd_t;

  typedef struct packed {
    logic chg;
    logic last;
    logic out_free;
  } pst_sts_t;

endpackage

// ===== hw/rtl/pst_in_if.sv =====
interface pst_in_if;
  import pst_pkg::*;

  logic              valid;
  logic              ready;
  logic [PORT_W-1:0] port_byte;
  logic [TIME_W-1:0] now_us;

  modport source (output valid, output port_byte, output now_us, input ready);
  modport sink (input valid, input port_byte, input now_us, output ready);
endinterface

// ===== hw/rtl/pst_out_if.sv =====
interface pst_out_if;
  import pst_pkg::*;

  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  switch_index;
  logic              new_level;
  logic              duration_valid;
  logic              spurious;
  logic [TIME_W-1:0] press_duration_us;
  logic              last_event;

  modport source (
    output valid, output switch_index, output new_level, output duration_valid,
    output spurious, output press_duration_us, output last_event, input ready
  );
  modport sink (
    input valid, input switch_index, input new_level, input duration_valid,
    input spurious, input press_duration_us, input last_event, output ready
  );
endinterface

// ===== hw/rtl/pst_cfg_if.sv =====
interface pst_cfg_if;
  import pst_pkg::*;

  logic               valid;
  logic               ready;
  logic [CFG_A_W-1:0] index;
  logic [MAP_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/pst_ctrl.sv =====
module pst_ctrl
  import pst_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  pst_sts_t sts_i,
  output pst_cmd_t cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             advance;

  assign in_ready_o = (state_q == ST_IDLE);
  assign advance    = !sts_i.chg || sts_i.out_free;

  assign cmd_o.load = in_valid_i && in_ready_o;
  assign cmd_o.emit = (state_q == ST_SCAN) && sts_i.chg && sts_i.out_free;
  assign cmd_o.idx  = idx_q;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.load) begin
          state_d = ST_SCAN;
          idx_d   = '0;
        end
      end
      ST_SCAN: begin
        if (advance) begin
          if (idx_q == LAST_IDX) begin
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + IDX_W'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

// ===== hw/rtl/pst_dp.sv =====
module pst_dp
  import pst_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  pst_in_if.sink   in_i,
  pst_out_if.source out_o,
  pst_cfg_if.sink  cfg_i,
  input  pst_cmd_t cmd_i,
  output pst_sts_t sts_o
);

  logic [EN_W-1:0]   enable_q;
  logic [MAP_W-1:0]  map_q;
  logic [MIN_W-1:0]  min_q;
  logic [PORT_W-1:0] port_q;
  logic [TIME_W-1:0] now_q;

  logic [NUM_SWITCHES-1:0] level_q;
  logic [NUM_SWITCHES-1:0] pvalid_q;
  logic [TIME_W-1:0]       stamp_q [NUM_SWITCHES];

  logic              out_valid_q;
  logic [IDX_W-1:0]  out_idx_q;
  logic              out_level_q;
  logic              out_dvalid_q;
  logic              out_spur_q;
  logic [TIME_W-1:0] out_dur_q;
  logic              out_last_q;

  logic [NUM_SWITCHES-1:0] chg;
  logic [NUM_SWITCHES-1:0] later;
  logic                    new_lvl;
  logic [TIME_W-1:0]       dur;
  logic                    short_press;

  always_comb begin
    for (int s = 0; s < NUM_SWITCHES; s++) begin
      chg[s]   = enable_q[s] &&
                 (port_q[map_q[SEL_W*s +: SEL_W]] != level_q[s]);
      later[s] = (IDX_W'(s) > cmd_i.idx);
    end
  end

  assign new_lvl     = ~level_q[cmd_i.idx];
  assign dur         = now_q - stamp_q[cmd_i.idx];
  assign short_press = (dur < {{(TIME_W-MIN_W){1'b0}}, min_q});

  assign sts_o.chg      = chg[cmd_i.idx];
  assign sts_o.last     = ~|(chg & later);
  assign sts_o.out_free = !out_valid_q || out_o.ready;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= SWITCH_ENABLE_RST;
      map_q    <= SWITCH_BIT_MAP_RST;
      min_q    <= MIN_PRESS_US_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_SWITCH_ENABLE:  enable_q <= cfg_i.data[EN_W-1:0];
        REG_SWITCH_BIT_MAP: map_q    <= cfg_i.data;
        REG_MIN_PRESS_US:   min_q    <= cfg_i.data[MIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      port_q <= in_i.port_byte;
      now_q  <= in_i.now_us;
    end
    if (cmd_i.emit && !new_lvl) begin
      stamp_q[cmd_i.idx] <= now_q;
    end
    if (cmd_i.emit) begin
      out_idx_q    <= cmd_i.idx;
      out_level_q  <= new_lvl;
      out_dvalid_q <= new_lvl && pvalid_q[cmd_i.idx] && !short_press;
      out_spur_q   <= new_lvl && pvalid_q[cmd_i.idx] && short_press;
      out_dur_q    <= (new_lvl && pvalid_q[cmd_i.idx] && !short_press) ? dur : '0;
      out_last_q   <= sts_o.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= '0;
      pvalid_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.emit) begin
        level_q[cmd_i.idx]  <= new_lvl;
        pvalid_q[cmd_i.idx] <= !new_lvl;
        out_valid_q         <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.switch_index      = out_idx_q;
  assign out_o.new_level         = out_level_q;
  assign out_o.duration_valid    = out_dvalid_q;
  assign out_o.spurious          = out_spur_q;
  assign out_o.press_duration_us = out_dur_q;
  assign out_o.last_event        = out_last_q;

endmodule

// ===== hw/rtl/polled_switch_press_timer_top.sv =====
// Polled switch press timer. Each request on the input channel is one poll of
// the 8-bit port together with its microsecond time. The block visits the
// switches in index order, one switch per clock cycle unless the receiver
// stalls, and emits one request on the output channel for every enabled switch
// whose mapped port bit differs from its stored level. A release that follows a
// recorded press carries the press duration, or the spurious flag when it is
// below the threshold. The final request caused by a poll has last_event set; a
// poll with no change emits nothing.
// A poll is taken while the block is idle and then scanned switch by switch;
// the block takes no new poll until that scan has ended. A result enters the
// output register in the cycle after its switch is visited. When the receiver
// stalls, the scan halts on the next changed switch until the output register
// is free.
// The configuration channel is always ready and writes one register per
// request; the user must use it only while the block is idle, and the block
// itself does not enforce this. Reset restores the register defaults, clears
// all switch levels and recorded presses, and empties the output register.
module polled_switch_press_timer_top
  import pst_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  pst_in_if.sink    in_i,
  pst_out_if.source out_o,
  pst_cfg_if.sink   cfg_i
);

  pst_cmd_t cmd;
  pst_sts_t sts;

  pst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pst_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o),
    .cfg_i  (cfg_i),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

endmodule
